/* rtl/blend_and_palette_snap_unit_assert.svh */
// Assertion macros shared by the blend and palette snap RTL.
`ifndef BLEND_AND_PALETTE_SNAP_UNIT_ASSERT_SVH
`define BLEND_AND_PALETTE_SNAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BPS_ASSERT(lbl, prop, msg)
`define BPS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/bps_pkg.sv */
// Shared types, constants and the channel blend function of the palette snap unit.
package bps_pkg;

  localparam int unsigned IDX_W     = 6;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;
  localparam logic [CH_W:0]    CH_MAX    = 9'd255;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BLEND = 1'b1;
  localparam logic MODE_AVG = 1'b0;
  localparam logic MODE_SAT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_BACK = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } srch_ctl_t;

  function automatic logic [COLOR_W-1:0] blend_px(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b,
                                                  input logic               mode);
    logic [COLOR_W-1:0] res;
    logic [CH_W:0]      s;
    res = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      s = {1'b0, a[c*CH_W +: CH_W]} + {1'b0, b[c*CH_W +: CH_W]};
      if (mode == MODE_SAT) begin
        res[c*CH_W +: CH_W] = (s > CH_MAX) ? CH_MAX[CH_W-1:0] : s[CH_W-1:0];
      end else begin
        res[c*CH_W +: CH_W] = s[CH_W:1];
      end
    end
    return res;
  endfunction

endpackage

/* rtl/bps_mem.sv */
// Palette store: one write port, one read port, registered read data.
module bps_mem
  import bps_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [COLOR_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [COLOR_W-1:0] rdata_o
);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bps_search.sv */
// Nearest-entry search: registered channel squares, then sum and running minimum.
module bps_search
  import bps_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srch_ctl_t          ctl_i,
  input  logic [AW-1:0]      idx_i,
  input  logic [COLOR_W-1:0] entry_i,
  input  logic [COLOR_W-1:0] ref_i,
  output logic               busy_o,
  output logic [AW-1:0]      best_idx_o,
  output logic [DIST_W-1:0]  best_dist_o
);

  logic [2*CH_W-1:0] sq_d [NUM_CH];
  logic [2*CH_W-1:0] sq_q [NUM_CH];
  logic              v_q;
  logic [AW-1:0]     idx_q;
  logic              first_q;
  logic [AW-1:0]     best_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [DIST_W-1:0] sum;
  logic              take;

  always_comb begin
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] t;
    for (int c = 0; c < NUM_CH; c++) begin
      x = entry_i[c*CH_W +: CH_W];
      y = ref_i[c*CH_W +: CH_W];
      t = (x > y) ? (x - y) : (y - x);
      sq_d[c] = (2*CH_W)'(t) * (2*CH_W)'(t);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      sq_q[c] <= sq_d[c];
    end
    idx_q <= idx_i;
  end

  assign sum  = DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
  assign take = v_q && (first_q || (sum < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      first_q <= 1'b1;
    end else begin
      v_q <= ctl_i.valid;
      if (ctl_i.clear) begin
        first_q <= 1'b1;
      end else if (v_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= idx_q;
      best_dist_q <= sum;
    end
  end

  assign busy_o      = v_q;
  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;

endmodule

/* rtl/blend_and_palette_snap_unit.sv */
// Blend and palette snap unit: input channel, sequencer, palette store and output word.
//
// Input words arrive on s_axis; tuser selects the operation. A write word stores
// one palette entry in the accept cycle and produces nothing. A blend word reads
// its backdrop entry, mixes it with the overlay color (average or saturating add),
// then walks the first active_count entries (clamped to 1..PALETTE_DEPTH), one
// palette read per cycle through the store's single read port, keeping the
// lowest index with the smallest squared distance.
// A blend's result word reaches m_axis through one read per searched entry (the
// backdrop read sits in the accept cycle), two search stages and the output
// load. The next word can be accepted in the cycle after the load, so a new
// blend is not taken before the last one is done. Writes are taken back to back.
// New words are accepted only between blends, but a result may still wait in the
// output register meanwhile; if the receiver stalls, the next blend holds at the
// end of its search until the pending word is taken.
// cfg_we_i writes active_count at any edge; write it only while idle.
// Reset empties the output register, returns to idle and sets active_count to 64.
// The palette is not cleared: every searched entry must be written before a blend.
module blend_and_palette_snap_unit
  import bps_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,     // active_count
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,  // index[5:0], color[29:6], zero pad
  input  logic [1:0]   s_axis_tuser_i,  // op[0], mode[1]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [47:0]  m_axis_tdata_o   // nearest_index[5:0], blended_color[29:6],
                                        // best_distance[47:30]
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned XW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
  localparam int unsigned CW = (NW > CNT_W) ? NW : CNT_W;

  `include "blend_and_palette_snap_unit_assert.svh"

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    active_count_q;
  logic [COLOR_W-1:0]  color_q;
  logic                mode_q;
  logic                in_range_q;
  logic [NW-1:0]       n_q;
  logic [NW-1:0]       iss_q, iss_d;
  logic                p1_v_q;
  logic [AW-1:0]       p1_idx_q;
  logic [COLOR_W-1:0]  mixed_q;
  logic                out_v_q;
  logic [47:0]         out_data_q;

  logic                accept;
  logic                in_op;
  logic                in_mode;
  logic [IDX_W-1:0]    in_idx;
  logic [COLOR_W-1:0]  in_color;
  logic [XW-1:0]       idx_ext;
  logic                idx_ok;
  logic [CW-1:0]       ac_ext;
  logic [CW-1:0]       n_clamp;
  logic                issue;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [COLOR_W-1:0]  mem_rdata;
  logic [COLOR_W-1:0]  backdrop;
  srch_ctl_t           srch_ctl;
  logic                srch_busy;
  logic [AW-1:0]       best_idx;
  logic [DIST_W-1:0]   best_dist;
  logic                done;
  logic                load;

  assign in_op    = s_axis_tuser_i[0];
  assign in_mode  = s_axis_tuser_i[1];
  assign in_idx   = s_axis_tdata_i[5:0];
  assign in_color = s_axis_tdata_i[29:6];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign idx_ext = XW'(in_idx);
  assign idx_ok  = idx_ext < XW'(PALETTE_DEPTH);

  always_comb begin
    ac_ext = CW'(active_count_q);
    if (ac_ext == '0) begin
      n_clamp = CW'(1);
    end else if (ac_ext > CW'(PALETTE_DEPTH)) begin
      n_clamp = CW'(PALETTE_DEPTH);
    end else begin
      n_clamp = ac_ext;
    end
  end

  assign issue  = ((state_q == ST_BACK) || (state_q == ST_SCAN)) && (iss_q < n_q);
  assign mem_we = accept && (in_op == OP_WRITE) && idx_ok;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = iss_q[AW-1:0];
    if (accept && (in_op == OP_BLEND)) begin
      mem_re    = idx_ok;
      mem_raddr = idx_ext[AW-1:0];
    end else if (issue) begin
      mem_re = 1'b1;
    end
  end

  bps_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (in_color),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign backdrop = in_range_q ? mem_rdata : '0;

  assign srch_ctl.clear = accept;
  assign srch_ctl.valid = p1_v_q;

  bps_search #(
    .DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (srch_ctl),
    .idx_i       (p1_idx_q),
    .entry_i     (mem_rdata),
    .ref_i       (mixed_q),
    .busy_o      (srch_busy),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  assign done = (state_q == ST_SCAN) && (iss_q == n_q) && !p1_v_q && !srch_busy;
  assign load = done && (!out_v_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    unique case (state_q)
      ST_IDLE: begin
        iss_d = '0;
        if (accept && (in_op == OP_BLEND)) begin
          state_d = ST_BACK;
        end
      end
      ST_BACK: begin
        iss_d   = iss_q + NW'(1);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          iss_d = iss_q + NW'(1);
        end
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_count_q <= CNT_RESET;
      iss_q          <= '0;
      p1_v_q         <= 1'b0;
      out_v_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      p1_v_q  <= issue;
      if (cfg_we_i) begin
        active_count_q <= cfg_wdata_i;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q    <= in_color;
      mode_q     <= in_mode;
      in_range_q <= idx_ok;
      n_q        <= NW'(n_clamp);
    end
    if (state_q == ST_BACK) begin
      mixed_q <= blend_px(backdrop, color_q, mode_q);
    end
    p1_idx_q <= iss_q[AW-1:0];
    if (load) begin
      out_data_q <= {best_dist, mixed_q, IDX_W'(best_idx)};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  `BPS_ASSERT(a_idle_pipe_empty, s_axis_tready_o |-> (!p1_v_q && !srch_busy),
              "input accepted while a search is in flight")
  `BPS_ASSERT(a_no_overwrite, load |-> (!out_v_q || m_axis_tready_i),
              "result word overwritten before it was taken")
  `BPS_ASSERT(a_issue_bound, (state_q == ST_SCAN) |-> (iss_q <= n_q),
              "palette read issued beyond the searched count")
  `BPS_ASSERT(a_back_to_scan, (state_q == ST_BACK) |=> (state_q == ST_SCAN),
              "backdrop read not followed by the search")
  `BPS_ASSERT_RST(a_reset_out, !rst_ni |=> !out_v_q,
                  "result word valid right after reset")

endmodule
